// File: rtl/core/tpaf_pkg.sv
// ----------------------------------------------------------------------------
// tpaf_pkg
// Shared types and constants of the triac phase-angle firing block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpaf_pkg;

    localparam int unsigned DELAY_W    = 10;   // max_delay and power width
    localparam int unsigned TICK_W     = 14;   // timer width
    localparam int unsigned WD_W       = 10;   // watchdog count width
    localparam int unsigned PROD_W     = 20;   // power * span
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [TICK_W-1:0]  PULSE_TICKS      = 14'd50;
    localparam logic [WD_W-1:0]    WATCHDOG_LIMIT   = 10'd800;
    localparam logic [WD_W-1:0]    WD_MAX           = 10'd1023;
    localparam logic [DELAY_W-1:0] POWER_FULL_SCALE = 10'd1000;
    localparam logic [DELAY_W-1:0] MAX_DELAY_LOW    = 10'd10;
    localparam logic [DELAY_W-1:0] MAX_DELAY_HIGH   = 10'd1000;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RESET  = 10'd900;

    // ceil(2^30 / 1000): exact floor division by 1000 for products below 2^20
    localparam int unsigned        RECIP_SHIFT = 30;
    localparam int unsigned        RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_1000  = 21'd1073742;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DELAY     = 2'd0,
        CFG_OUTPUT_SELECT = 2'd1,
        CFG_ENABLED       = 2'd2
    } t_cfg_idx;

    // Configuration as seen by the datapath, with the delay terms worked out
    typedef struct packed {
        logic [TICK_W-1:0]  md_x10;    // clamped max_delay * 10
        logic [DELAY_W-1:0] span;      // clamped max_delay - 10
        logic               output_select;
        logic               enabled;
        logic               clear;     // pulse: enabled written to 0
    } t_cfg;

    // Input item held in the input register
    typedef struct packed {
        logic               zero_cross;
        logic               power_nz;
        logic               wd_load;
        logic [WD_W-1:0]    wd_value;
        logic [PROD_W-1:0]  product;   // saturated power * span
    } t_stage;

    typedef struct packed {
        logic gate_level;
        logic restart_flag;
        logic timer_running;
        logic fire_pending;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/tpaf_in_if.sv
// ----------------------------------------------------------------------------
// tpaf_in_if
// Tick item channel: valid/ready handshake with the tick payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpaf_in_if;
    logic       valid;
    logic       ready;
    logic       zero_cross;
    logic [9:0] power_level;
    logic       wd_load;
    logic [9:0] wd_value;

    modport source (output valid, zero_cross, power_level, wd_load, wd_value,
                    input ready);
    modport sink   (input valid, zero_cross, power_level, wd_load, wd_value,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/tpaf_out_if.sv
// ----------------------------------------------------------------------------
// tpaf_out_if
// Result item channel: valid/ready handshake with the gate and restart levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpaf_out_if;
    logic valid;
    logic ready;
    logic gate_main;
    logic gate_alt;
    logic restart_request;

    modport source (output valid, gate_main, gate_alt, restart_request,
                    input ready);
    modport sink   (input valid, gate_main, gate_alt, restart_request,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/triac_phase_angle_firing.sv
// ----------------------------------------------------------------------------
// triac_phase_angle_firing
// Triac phase-angle firing controller, one item per 1 us tick.
// ----------------------------------------------------------------------------
// Each accepted tick item yields exactly one result item holding the gate
// levels and the sticky restart request after that tick. The block takes one
// item per clock cycle when the result side is ready; a result is offered
// after its item has passed the input register and then the result register.
// The rate is set by the state update loop of the firing timer. Power times
// span is multiplied on entry to the input register; the division by full
// scale is a reciprocal multiply before the state update. Configuration
// writes take effect at the next clock and are to be made only while no
// items are in flight.
`default_nettype none

module triac_phase_angle_firing (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tpaf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tpaf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    tpaf_in_if.sink                              i_item,
    tpaf_out_if.source                           o_result
);
    import tpaf_pkg::*;

    t_cfg               w_cfg;
    t_status            w_next;
    t_status            w_state;

    logic               r_in_valid, n_in_valid;
    t_stage             r_in, n_in;
    logic               r_out_valid, n_out_valid;
    logic               r_out_main, r_out_alt, r_out_restart;

    logic               w_in_take;
    logic               w_advance;
    logic [DELAY_W-1:0] w_power_sat;

    tpaf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    tpaf_fire_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_advance),
        .i_stage (r_in),
        .o_next  (w_next),
        .o_state (w_state)
    );

    // the held item moves on when the result register is free or being taken
    assign w_advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || w_advance;
    assign w_in_take      = i_item.valid && i_item.ready;

    assign w_power_sat = (i_item.power_level > POWER_FULL_SCALE) ?
                         POWER_FULL_SCALE : i_item.power_level;

    always_comb begin
        n_in            = r_in;
        n_in_valid      = r_in_valid;
        if (w_in_take) begin
            n_in.zero_cross = i_item.zero_cross;
            n_in.power_nz   = (i_item.power_level != '0);
            n_in.wd_load    = i_item.wd_load;
            n_in.wd_value   = i_item.wd_value;
            n_in.product    = PROD_W'(w_power_sat) * PROD_W'(w_cfg.span);
            n_in_valid      = 1'b1;
        end else if (w_advance) begin
            n_in_valid      = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        if (w_advance) begin
            r_out_main    <= w_next.gate_level & ~w_cfg.output_select;
            r_out_alt     <= w_next.gate_level &  w_cfg.output_select;
            r_out_restart <= w_next.restart_flag;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.gate_main       = r_out_main;
    assign o_result.gate_alt        = r_out_alt;
    assign o_result.restart_request = r_out_restart;

`ifndef NO_ASSERTIONS
    a_gates_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.gate_main && o_result.gate_alt))
        else $error("both gate outputs high");

    a_restart_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state.restart_flag |=> w_state.restart_flag)
        else $error("restart flag dropped");

    a_pending_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state.fire_pending |-> w_state.timer_running)
        else $error("firing pending with timer stopped");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("held item lost or changed");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tpaf_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpaf_cfg_regs
// Configuration registers; clamps max_delay and precomputes the delay terms.
// ----------------------------------------------------------------------------
`default_nettype none

module tpaf_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tpaf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tpaf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output tpaf_pkg::t_cfg                         o_cfg
);
    import tpaf_pkg::*;

    logic [TICK_W-1:0]  r_md_x10, n_md_x10;
    logic [DELAY_W-1:0] r_span, n_span;
    logic               r_sel, n_sel;
    logic               r_en, n_en;
    logic               w_clear;
    logic [DELAY_W-1:0] w_md;

    always_comb begin
        if (i_cfg_wdata < MAX_DELAY_LOW) begin
            w_md = MAX_DELAY_LOW;
        end else if (i_cfg_wdata > MAX_DELAY_HIGH) begin
            w_md = MAX_DELAY_HIGH;
        end else begin
            w_md = i_cfg_wdata;
        end
    end

    always_comb begin
        n_md_x10 = r_md_x10;
        n_span   = r_span;
        n_sel    = r_sel;
        n_en     = r_en;
        w_clear  = 1'b0;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_DELAY: begin
                    n_md_x10 = {1'b0, w_md, 3'b000} + {3'b000, w_md, 1'b0};
                    n_span   = w_md - MAX_DELAY_LOW;
                end
                CFG_OUTPUT_SELECT: begin
                    n_sel = i_cfg_wdata[0];
                end
                CFG_ENABLED: begin
                    n_en    = i_cfg_wdata[0];
                    w_clear = ~i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md_x10 <= {1'b0, MAX_DELAY_RESET, 3'b000} + {3'b000, MAX_DELAY_RESET, 1'b0};
            r_span   <= MAX_DELAY_RESET - MAX_DELAY_LOW;
            r_sel    <= 1'b0;
            r_en     <= 1'b1;
        end else begin
            r_md_x10 <= n_md_x10;
            r_span   <= n_span;
            r_sel    <= n_sel;
            r_en     <= n_en;
        end
    end

    assign o_cfg.md_x10        = r_md_x10;
    assign o_cfg.span          = r_span;
    assign o_cfg.output_select = r_sel;
    assign o_cfg.enabled       = r_en;
    assign o_cfg.clear         = w_clear;

endmodule

`default_nettype wire

// File: rtl/core/tpaf_fire_ctrl.sv
// ----------------------------------------------------------------------------
// tpaf_fire_ctrl
// Per-tick state update: watchdog, delay/pulse timer and zero-cross arming.
// ----------------------------------------------------------------------------
`default_nettype none

module tpaf_fire_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tpaf_pkg::t_cfg    i_cfg,
    input  wire logic              i_step,
    input  wire tpaf_pkg::t_stage  i_stage,
    output tpaf_pkg::t_status      o_next,   // state after this tick's update
    output tpaf_pkg::t_status      o_state
);
    import tpaf_pkg::*;

    logic [TICK_W-1:0]             r_tick, n_tick;
    logic [TICK_W-1:0]             r_alarm, n_alarm;
    logic                          r_running, n_running;
    logic                          r_pending, n_pending;
    logic                          r_gate, n_gate;
    logic [WD_W-1:0]               r_wd, n_wd;
    logic                          r_restart, n_restart;

    logic [PROD_W+RECIP_W-1:0]     w_qprod;
    logic [DELAY_W-1:0]            w_q;
    logic [TICK_W-1:0]             w_delay;
    logic [TICK_W-1:0]             w_tick_inc;

    // trunc(p * (10 - md) / 1000) as a magnitude, via reciprocal multiply
    assign w_qprod    = (PROD_W+RECIP_W)'(i_stage.product) * (PROD_W+RECIP_W)'(RECIP_1000);
    assign w_q        = w_qprod[RECIP_SHIFT +: DELAY_W];
    assign w_delay    = i_cfg.md_x10 - ({1'b0, w_q, 3'b000} + {3'b000, w_q, 1'b0});
    assign w_tick_inc = r_tick + 1'b1;

    always_comb begin
        n_tick    = r_tick;
        n_alarm   = r_alarm;
        n_running = r_running;
        n_pending = r_pending;
        n_gate    = r_gate;
        n_wd      = r_wd;
        n_restart = r_restart;
        if (i_cfg.clear) begin
            n_pending = 1'b0;
            n_gate    = 1'b0;
            n_running = 1'b0;
            n_tick    = '0;
        end else if (i_step) begin
            if (i_stage.wd_load) begin
                n_wd = i_stage.wd_value;
            end
            if (r_running) begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= r_alarm) begin
                    n_tick = '0;
                    if (n_wd != '0 && n_wd != WD_MAX) begin
                        n_wd = n_wd + 1'b1;
                    end
                    if (n_wd > WATCHDOG_LIMIT) begin
                        n_restart = 1'b1;
                    end
                    if (r_pending) begin
                        n_gate    = 1'b1;
                        n_alarm   = PULSE_TICKS;
                        n_running = 1'b1;
                        n_pending = 1'b0;
                    end else begin
                        n_gate    = 1'b0;
                        n_running = 1'b0;
                    end
                end
            end
            if (i_stage.zero_cross && i_cfg.enabled) begin
                n_gate = 1'b0;
                if (i_stage.power_nz) begin
                    n_pending = 1'b1;
                    n_alarm   = w_delay;
                    n_tick    = '0;
                    n_running = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_alarm   <= '0;
            r_running <= 1'b0;
            r_pending <= 1'b0;
            r_gate    <= 1'b0;
            r_wd      <= '0;
            r_restart <= 1'b0;
        end else begin
            r_tick    <= n_tick;
            r_alarm   <= n_alarm;
            r_running <= n_running;
            r_pending <= n_pending;
            r_gate    <= n_gate;
            r_wd      <= n_wd;
            r_restart <= n_restart;
        end
    end

    assign o_next.gate_level     = n_gate;
    assign o_next.restart_flag   = n_restart;
    assign o_next.timer_running  = n_running;
    assign o_next.fire_pending   = n_pending;

    assign o_state.gate_level    = r_gate;
    assign o_state.restart_flag  = r_restart;
    assign o_state.timer_running = r_running;
    assign o_state.fire_pending  = r_pending;

endmodule

`default_nettype wire
